// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/urm_pkg.sv =====
`default_nettype none

package urm_pkg;

  // Field widths
  localparam int DIST_W = 10;
  localparam int TICK_W = 16;
  localparam int TRIG_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PING_TO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_HI  = 2'd3;

  // Configuration reset values
  localparam logic [DIST_W-1:0] MAX_DIST_RST = 10'd500;
  localparam logic [TICK_W-1:0] PING_TO_RST  = 16'd6000;
  localparam logic [TRIG_W-1:0] TRIG_LOW_RST = 8'd4;
  localparam logic [TRIG_W-1:0] TRIG_HI_RST  = 8'd10;

  // Measurement phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
  localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
  localparam logic [2:0] PH_WAIT_ECHO = 3'd3;
  localparam logic [2:0] PH_MEASURE   = 3'd4;

  // Completion status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_ECHO_HIGH    = 2'd1;
  localparam logic [1:0] ST_PING_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_ECHO_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [DIST_W-1:0] max_range_cm;
    logic [TICK_W-1:0] ping_timeout_ticks;
    logic [TRIG_W-1:0] trigger_low_ticks;
    logic [TRIG_W-1:0] trigger_high_ticks;
  } cfg_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        status;
    logic [DIST_W-1:0] distance_cm;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/urm_cfg.sv =====
`default_nettype none

module urm_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic [urm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [urm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output urm_pkg::cfg_t                         cfg
);
  import urm_pkg::*;

  // Register file; writes are always taken
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_range_cm       <= MAX_DIST_RST;
      cfg.ping_timeout_ticks <= PING_TO_RST;
      cfg.trigger_low_ticks  <= TRIG_LOW_RST;
      cfg.trigger_high_ticks <= TRIG_HI_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_DIST: cfg.max_range_cm       <= cfg_data[DIST_W-1:0];
        REG_PING_TO:  cfg.ping_timeout_ticks <= cfg_data[TICK_W-1:0];
        REG_TRIG_LOW: cfg.trigger_low_ticks  <= cfg_data[TRIG_W-1:0];
        REG_TRIG_HI:  cfg.trigger_high_ticks <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/urm_core.sv =====
`default_nettype none

module urm_core #(
  parameter int TICKS_PER_CM = 58
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic          cmd,
  input  wire logic          echo_level,
  input  wire urm_pkg::cfg_t cfg,
  output urm_pkg::res_t      res_next
);
  import urm_pkg::*;

  localparam int SubW = (TICKS_PER_CM < 2) ? 1 : $clog2(TICKS_PER_CM + 1);
  localparam logic [SubW-1:0] SubLimit = SubW'(TICKS_PER_CM);

  logic [2:0]        phase, phase_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [DIST_W-1:0] cm_count, cm_count_next;
  logic [SubW-1:0]   cm_sub_count, cm_sub_count_next;

  logic [TICK_W-1:0] tick_inc;
  logic [TRIG_W-1:0] high_len;
  logic [SubW-1:0]   sub_inc;
  logic [DIST_W-1:0] cm_sat;
  logic              fin;
  logic [1:0]        fin_status;
  logic [DIST_W-1:0] fin_dist;

  assign tick_inc = tick_count + 1'b1;
  assign high_len = (cfg.trigger_high_ticks == '0) ? TRIG_W'(1) : cfg.trigger_high_ticks;
  assign sub_inc  = cm_sub_count + 1'b1;
  assign cm_sat   = (cm_count != '1) ? cm_count + 1'b1 : cm_count;

  // Phase step for one transaction
  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    cm_count_next     = cm_count;
    cm_sub_count_next = cm_sub_count;
    fin               = 1'b0;
    fin_status        = ST_OK;
    fin_dist          = '0;
    if (cmd) begin
      if (phase == PH_IDLE) begin
        tick_count_next   = '0;
        cm_count_next     = '0;
        cm_sub_count_next = '0;
        phase_next = (cfg.trigger_low_ticks == '0) ? PH_TRIG_HIGH : PH_TRIG_LOW;
      end
    end else begin
      case (phase)
        PH_IDLE: ;
        PH_TRIG_LOW: begin
          tick_count_next = tick_inc;
          if (tick_inc >= {{(TICK_W-TRIG_W){1'b0}}, cfg.trigger_low_ticks}) begin
            tick_count_next = '0;
            phase_next      = PH_TRIG_HIGH;
          end
        end
        PH_TRIG_HIGH: begin
          tick_count_next = tick_inc;
          if (tick_inc >= {{(TICK_W-TRIG_W){1'b0}}, high_len}) begin
            tick_count_next = '0;
            if (echo_level) begin
              fin        = 1'b1;
              fin_status = ST_ECHO_HIGH;
            end else begin
              phase_next = PH_WAIT_ECHO;
            end
          end
        end
        PH_WAIT_ECHO: begin
          if (echo_level) begin
            tick_count_next   = '0;
            cm_count_next     = '0;
            cm_sub_count_next = '0;
            phase_next        = PH_MEASURE;
          end else begin
            // saturating wait counter
            tick_count_next = (tick_count != '1) ? tick_inc : tick_count;
            if (tick_count_next >= cfg.ping_timeout_ticks) begin
              fin        = 1'b1;
              fin_status = ST_PING_TIMEOUT;
            end
          end
        end
        PH_MEASURE: begin
          if (!echo_level) begin
            fin        = 1'b1;
            fin_status = ST_OK;
            fin_dist   = cm_count;
          end else begin
            cm_sub_count_next = sub_inc;
            if (sub_inc >= SubLimit) begin
              cm_sub_count_next = '0;
              cm_count_next     = cm_sat;
            end
            if (cm_count_next >= cfg.max_range_cm) begin
              fin        = 1'b1;
              fin_status = ST_ECHO_TIMEOUT;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
    if (fin) begin
      phase_next      = PH_IDLE;
      tick_count_next = '0;
    end
  end

  // Result for this transaction
  always_comb begin
    res_next.trigger_level = !fin && (phase_next == PH_TRIG_HIGH);
    res_next.busy_res      = !fin && (phase_next != PH_IDLE);
    res_next.done_res      = fin;
    res_next.status        = fin_status;
    res_next.distance_cm   = fin_dist;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      cm_count     <= '0;
      cm_sub_count <= '0;
    end else if (take) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      cm_count     <= cm_count_next;
      cm_sub_count <= cm_sub_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ultrasonic_range_meter.sv =====
// Ultrasonic range meter, one tick transaction per cycle unless the output stalls.
// Latency: result is valid on the cycle after the input transaction is accepted.
// Throughput: one transaction per clock; the single output register stalls input
// only while its result is held by out_ready low.
// Reset: phase idle, counters cleared, registers back to 500 cm / 6000 / 4 / 10.
`default_nettype none

module ultrasonic_range_meter #(
  parameter int TICKS_PER_CM = 58
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output wire logic                              cfg_ready,
  input  wire logic [urm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [urm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output wire logic                              in_ready,
  input  wire logic                              cmd,
  input  wire logic                              echo_level,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   trigger_level,
  output logic                                   busy_res,
  output logic                                   done_res,
  output logic [1:0]                             status,
  output logic [urm_pkg::DIST_W-1:0]             distance_cm
);
  import urm_pkg::*;

  cfg_t cfg;
  res_t res_next;
  logic take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign take      = in_valid && in_ready;

  urm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  urm_core #(
    .TICKS_PER_CM (TICKS_PER_CM)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .cmd        (cmd),
    .echo_level (echo_level),
    .cfg        (cfg),
    .res_next   (res_next)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (take) begin
      trigger_level <= res_next.trigger_level;
      busy_res      <= res_next.busy_res;
      done_res      <= res_next.done_res;
      status        <= res_next.status;
      distance_cm   <= res_next.distance_cm;
    end
  end

endmodule

`default_nettype wire

// ===== sv/urm_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module urm_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic                           trigger_level,
  input wire logic                           busy_res,
  input wire logic                           done_res,
  input wire logic [1:0]                     status,
  input wire logic [urm_pkg::DIST_W-1:0]     distance_cm
);
  import urm_pkg::*;

  // A held result keeps its payload
  `ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(distance_cm))

  // Every accepted transaction produces a result next cycle
  `ASSERT_NXT(a_result, clk, rst, in_valid && in_ready, out_valid)

  // A finished measurement drops busy and trigger
  `ASSERT_IMP(a_done_idle, clk, rst, out_valid && done_res, !busy_res && !trigger_level)

  // Status and distance only on completion, distance only when ok
  `ASSERT_IMP(a_status, clk, rst, out_valid && !done_res, status == ST_OK && distance_cm == '0)
  `ASSERT_IMP(a_dist, clk, rst, out_valid && distance_cm != '0, done_res && status == ST_OK)

endmodule

bind ultrasonic_range_meter urm_checker u_urm_checker (.*);

`default_nettype wire
